@@ rtl/rtsm_pkg.sv @@
`default_nettype none
package rtsm_pkg;

  localparam int MAX_REGIONS   = 32;
  localparam int OFFSET_BITS   = 48;
  localparam int RESOURCE_BITS = 16;

  localparam int ADDR_W     = 48;
  localparam int ROFF_W     = 64;
  localparam int RES_PORT_W = 16;
  localparam int CNT_PORT_W = 6;

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int RES_W = (RESOURCE_BITS < RES_PORT_W) ? RESOURCE_BITS : RES_PORT_W;

  localparam logic [ADDR_W-1:0] OFFSET_MASK = (OFFSET_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                              ADDR_W'((65'd1 << OFFSET_BITS) - 65'd1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_MAP    = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_INVAL = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_SMALL = 3'd4;

  localparam logic KIND_SPAN   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [RES_W-1:0]  res;
    logic [ROFF_W-1:0] base;
    logic [ADDR_W-1:0] lstart;
    logic [ADDR_W-1:0] lend;
  } region_t;

endpackage
`default_nettype wire

@@ rtl/region_table_span_mapper_unit.sv @@
`default_nettype none
// Region table span mapper. Pulse start with a command while busy is low; every command
// returns its result transactions on the out_ ports, each valid for exactly one cycle
// with out_valid, ending with a status transaction that has out_last set. The receiver
// cannot stall. Clear, append and unknown commands, and a map that is out of range or
// empty, never raise busy; their status passes through pend_r and the output registers.
// A map walks the region table one entry per cycle (one read of the table RAM each
// cycle), from entry 0 up to the last region it touches, then closes in S_DONE; a gap
// or the table's end stops it early with ST_INVAL. Spans pass through pend_r and output
// registers. cfg_we writes limit_r, the append byte limit; it only affects later appends.
module region_table_span_mapper_unit import rtsm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [47:0] in_logical_offset,
  input  logic [47:0] in_byte_count,
  input  logic [15:0] in_resource_index,
  input  logic [63:0] in_resource_offset,
  input  logic [5:0]  in_span_capacity,
  input  logic        cfg_we,
  input  logic [47:0] cfg_data,
  output logic        out_valid,
  output logic        out_item_kind,
  output logic [15:0] out_span_resource,
  output logic [63:0] out_span_resource_offset,
  output logic [47:0] out_span_dest_offset,
  output logic [47:0] out_span_bytes,
  output logic [2:0]  out_status,
  output logic [5:0]  out_required_spans,
  output logic [47:0] out_total_bytes,
  output logic [5:0]  out_regions_held,
  output logic        out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [RES_W-1:0]  res;
    logic [ROFF_W-1:0] base;
    logic [ADDR_W-1:0] offs;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] nbytes;
    logic [2:0]        st;
    logic [CNT_W-1:0]  req;
  } pend_t;

  function automatic pend_t mk_status(input logic [2:0] st, input logic [CNT_W-1:0] req);
    pend_t p;
    p      = '0;
    p.kind = KIND_STATUS;
    p.st   = st;
    p.req  = req;
    return p;
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] limit_r;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [ADDR_W-1:0] size_r, size_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [ADDR_W-1:0] rstart_r, rstart_nxt;
  logic [ADDR_W-1:0] rend_r, rend_nxt;
  logic              p_valid_r, p_valid_nxt;
  pend_t             pend_r, pend_nxt;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [15:0]       out_res_r;
  logic [63:0]       out_roff_r;
  logic [47:0]       out_dest_r;
  logic [47:0]       out_bytes_r;
  logic [2:0]        out_status_r;
  logic [5:0]        out_req_r;
  logic [47:0]       out_total_r;
  logic [5:0]        out_held_r;
  logic              out_last_r;

  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_raddr;
  region_t           tbl_wdata;
  region_t           rd;

  logic              accept;
  logic [ADDR_W-1:0] a_start, a_len, app_sum;
  logic              app_full, app_bad;
  logic [ADDR_W:0]   map_sum;
  logic              map_oor;
  logic [CNT_W-1:0]  cap_in;
  logic              w_past, w_skip, w_gap, w_fin;
  logic [ADDR_W-1:0] w_end;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign a_start  = in_logical_offset & OFFSET_MASK;
  assign a_len    = in_byte_count & OFFSET_MASK;
  assign app_sum  = size_r + a_len;
  assign app_full = (total_r >= CNT_W'(MAX_REGIONS));
  assign app_bad  = (a_len == '0) || (a_start != size_r) ||
                    (~in_resource_offset < ROFF_W'(a_len)) ||
                    (a_len > limit_r) || (size_r > limit_r - a_len);
  assign map_sum  = {1'b0, a_start} + {1'b0, a_len};
  assign map_oor  = (a_start > size_r) || (map_sum > {1'b0, size_r});
  assign cap_in   = (in_span_capacity > 6'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) :
                                                           in_span_capacity[CNT_W-1:0];

  assign w_past = (idx_r == total_r);
  assign w_skip = (cursor_r >= rd.lend);
  assign w_gap  = (cursor_r < rd.lstart);
  assign w_fin  = (rd.lend >= rend_r);
  assign w_end  = w_fin ? rend_r : rd.lend;

  rtsm_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (total_r[IDX_W-1:0]),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (rd)
  );

  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    size_nxt    = size_r;
    idx_nxt     = idx_r;
    used_nxt    = used_r;
    cap_nxt     = cap_r;
    cursor_nxt  = cursor_r;
    rstart_nxt  = rstart_r;
    rend_nxt    = rend_r;
    p_valid_nxt = 1'b0;
    pend_nxt    = pend_r;
    tbl_we      = 1'b0;
    tbl_raddr   = '0;
    tbl_wdata   = '{res: in_resource_index[RES_W-1:0], base: in_resource_offset,
                    lstart: a_start, lend: app_sum};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          p_valid_nxt = 1'b1;
          case (in_command)
            CMD_CLEAR: begin
              total_nxt = '0;
              size_nxt  = '0;
              pend_nxt  = mk_status(ST_OK, '0);
            end
            CMD_APPEND: begin
              if (app_full) begin
                pend_nxt = mk_status(ST_FULL, '0);
              end else if (app_bad) begin
                pend_nxt = mk_status(ST_INVAL, '0);
              end else begin
                tbl_we    = 1'b1;
                total_nxt = total_r + 1'b1;
                size_nxt  = app_sum;
                pend_nxt  = mk_status(ST_OK, '0);
              end
            end
            CMD_MAP: begin
              if (map_oor) begin
                pend_nxt = mk_status(ST_RANGE, '0);
              end else if (a_len == '0) begin
                pend_nxt = mk_status(ST_OK, '0);
              end else begin
                p_valid_nxt = 1'b0;
                state_nxt   = S_WALK;
                idx_nxt     = '0;
                used_nxt    = '0;
                cap_nxt     = cap_in;
                cursor_nxt  = a_start;
                rstart_nxt  = a_start;
                rend_nxt    = map_sum[ADDR_W-1:0];
              end
            end
            default: begin
              pend_nxt = mk_status(ST_INVAL, '0);
            end
          endcase
        end
      end
      S_WALK: begin
        tbl_raddr = IDX_W'(idx_r + 1'b1);
        idx_nxt   = idx_r + 1'b1;
        if (w_past || (!w_skip && w_gap)) begin
          p_valid_nxt = 1'b1;
          pend_nxt    = mk_status(ST_INVAL, used_r);
          state_nxt   = S_IDLE;
        end else if (!w_skip) begin
          if (used_r < cap_r) begin
            p_valid_nxt     = 1'b1;
            pend_nxt        = '0;
            pend_nxt.kind   = KIND_SPAN;
            pend_nxt.res    = rd.res;
            pend_nxt.base   = rd.base;
            pend_nxt.offs   = cursor_r - rd.lstart;
            pend_nxt.dest   = cursor_r - rstart_r;
            pend_nxt.nbytes = w_end - cursor_r;
          end
          used_nxt   = used_r + 1'b1;
          cursor_nxt = w_end;
          if (w_fin) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        p_valid_nxt = 1'b1;
        pend_nxt    = mk_status((used_r <= cap_r) ? ST_OK : ST_SMALL, used_r);
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= {ADDR_W{1'b1}};
      total_r     <= '0;
      size_r      <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      size_r      <= size_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= p_valid_r;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    used_r   <= used_nxt;
    cap_r    <= cap_nxt;
    cursor_r <= cursor_nxt;
    rstart_r <= rstart_nxt;
    rend_r   <= rend_nxt;
    pend_r   <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    out_kind_r <= pend_r.kind;
    if (pend_r.kind == KIND_SPAN) begin
      out_res_r    <= RES_PORT_W'(pend_r.res);
      out_roff_r   <= pend_r.base + ROFF_W'(pend_r.offs);
      out_dest_r   <= pend_r.dest;
      out_bytes_r  <= pend_r.nbytes;
      out_status_r <= '0;
      out_req_r    <= '0;
      out_total_r  <= '0;
      out_held_r   <= '0;
      out_last_r   <= 1'b0;
    end else begin
      out_res_r    <= '0;
      out_roff_r   <= '0;
      out_dest_r   <= '0;
      out_bytes_r  <= '0;
      out_status_r <= pend_r.st;
      out_req_r    <= CNT_PORT_W'(pend_r.req);
      out_total_r  <= size_r;
      out_held_r   <= CNT_PORT_W'(total_r);
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_item_kind            = out_kind_r;
  assign out_span_resource        = out_res_r;
  assign out_span_resource_offset = out_roff_r;
  assign out_span_dest_offset     = out_dest_r;
  assign out_span_bytes           = out_bytes_r;
  assign out_status               = out_status_r;
  assign out_required_spans       = out_req_r;
  assign out_total_bytes          = out_total_r;
  assign out_regions_held         = out_held_r;
  assign out_last                 = out_last_r;

  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command != CMD_MAP) |-> ##2 (out_valid && out_last))
    else $error("single-cycle command did not return status");

  a_map_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ##2 (out_valid && out_last && out_required_spans != '0))
    else $error("map close did not return status");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (used_r <= idx_r && idx_r <= total_r))
    else $error("walk counters out of order");

  a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r == '0) |-> (size_r == '0))
    else $error("empty table with nonzero logical size");

endmodule
`default_nettype wire

@@ rtl/rtsm_table.sv @@
`default_nettype none
module rtsm_table import rtsm_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  region_t          wdata,
  input  logic [IDX_W-1:0] raddr,
  output region_t          rdata
);

  region_t mem [MAX_REGIONS];
  region_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
